// ----- design/wert_pkg.sv -----
// ============================================================================
// wert_pkg: shared types and constants of the windowed event rate tracker
// Field widths, payload structs, sequencer states and the storage command
// group used between the sequencer and the ring storage.
// ============================================================================
package wert_pkg;

  // Fixed field widths.
  localparam int CTR_IDX_W = 6;
  localparam int TOTAL_W   = 64;
  localparam int SLOTS_W   = 10;
  localparam int CNT_W     = 32;
  localparam int DIV_CNT_W = $clog2(CNT_W);

  // Default sizing.
  localparam int COUNTERS_DEF       = 64;
  localparam int INTERVAL_SLOTS_DEF = 12;
  localparam int MINUTE_SLOTS_DEF   = 60;

  typedef struct packed {
    logic [CTR_IDX_W-1:0] counter_index;
    logic [TOTAL_W-1:0]   current_total;
    logic [SLOTS_W-1:0]   slots;
    logic                 end_of_run;
  } in_item_t;

  typedef struct packed {
    logic [CTR_IDX_W-1:0] counter_echo;
    logic [CNT_W-1:0]     interval_count;
    logic [CNT_W-1:0]     minute_sum;
    logic [CNT_W-1:0]     hour_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDPREV,
    ST_START,
    ST_DIV,
    ST_LOAD,
    ST_FILL,
    ST_SUM,
    ST_TAIL,
    ST_OUT
  } wert_state_e;

  typedef struct packed {
    logic prev_we;
    logic ir_we;
    logic mr_we;
  } store_cmd_t;

endpackage

// ----- design/windowed_event_rate_tracker.sv -----
// ============================================================================
// windowed_event_rate_tracker: sliding-window event rate counter
// Spreads each counter's new events over interval slots and reports the
// newest slot, the interval-ring sum and the minute-ring sum.
// ============================================================================
// Usage: the input channel (in_valid_i/in_ready_o/in_data_i) takes one update
// per transfer: a counter index, its running total, the number of elapsed
// intervals and an end-of-run flag. The output channel (out_valid_o/
// out_ready_i/out_data_o) returns exactly one result per update.
// Timing: the block handles one update at a time and drops in_ready_o while
// it works. An in-range update passes through the bit-serial divider, then
// writes its slots to the rings one after another, then reads the ring
// entries one by one for the sums, since each ring memory has a single read
// port, with the read, start, load, tail and output steps around them. An
// out-of-range index still runs the slot loop without ring writes, so the
// shared ring position can still move on an end-of-run update. in_ready_o
// returns in the cycle after the result is loaded. The first update of a
// counter after reset also zeroes that counter's ring rows, one entry per
// cycle, and the divider step lasts until both the division and the zeroing
// are done.
// Reset: rst_ni clears the ring position and the per-counter valid flags, so
// every counter reads as zero history without a clearing pass after reset.
// Stall: a result waits in the output register; the block takes the next
// update meanwhile and holds that one's result until the output drains.
// ============================================================================
module windowed_event_rate_tracker import wert_pkg::*; #(
  parameter int COUNTERS       = COUNTERS_DEF,
  parameter int INTERVAL_SLOTS = INTERVAL_SLOTS_DEF,
  parameter int MINUTE_SLOTS   = MINUTE_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // Only indexes that the 6-bit field can reach get storage.
  localparam int IdxSpan  = 1 << CTR_IDX_W;
  localparam int CtrDepth = (COUNTERS < IdxSpan) ? COUNTERS : IdxSpan;
  localparam int CtrW     = (CtrDepth > 1) ? $clog2(CtrDepth) : 1;
  localparam int IsW      = $clog2(INTERVAL_SLOTS);
  localparam int MsW      = $clog2(MINUTE_SLOTS);
  localparam int KMax     = (INTERVAL_SLOTS > MINUTE_SLOTS) ? INTERVAL_SLOTS : MINUTE_SLOTS;
  localparam int KW       = $clog2(KMax);
  localparam int CmpW     = ($clog2(COUNTERS + 1) > CTR_IDX_W) ? $clog2(COUNTERS + 1)
                                                               : CTR_IDX_W;

  wert_state_e state_q, state_d;

  // Captured update.
  in_item_t           item_q;
  logic               ctr_ok_q;
  logic [SLOTS_W-1:0] slots_q;

  // Per-counter history flags and the shared ring position, kept as an
  // interval index and a minute index.
  logic [CtrDepth-1:0] row_vld_q;
  logic [IsW-1:0]      pos_m_q;
  logic [MsW-1:0]      pos_h_q;

  // Working registers of the slot loop and the summing sweep.
  logic [IsW-1:0]     m_q;
  logic [MsW-1:0]     h_q;
  logic [SLOTS_W-1:0] j_q;
  logic [KW-1:0]      k_q;
  logic               clr_q;
  logic               first_q;
  logic [CNT_W-1:0]   part_q;
  logic [CNT_W-1:0]   vlast_q;
  logic [CNT_W-1:0]   acc_q;
  logic [CNT_W-1:0]   newest_q;
  logic [CNT_W-1:0]   msum_q;
  logic [CNT_W-1:0]   hsum_q;
  logic               irv_q;
  logic               mrv_q;

  logic      out_valid_q;
  out_item_t out_q;

  // Storage and divider connections.
  store_cmd_t         cmd;
  logic [CtrW-1:0]    row;
  logic [TOTAL_W-1:0] prev_rdata;
  logic [IsW-1:0]     ir_waddr;
  logic [CNT_W-1:0]   ir_wdata;
  logic [IsW-1:0]     ir_raddr;
  logic [CNT_W-1:0]   ir_rdata;
  logic [MsW-1:0]     mr_waddr;
  logic [CNT_W-1:0]   mr_wdata;
  logic [MsW-1:0]     mr_raddr;
  logic [CNT_W-1:0]   mr_rdata;
  logic               div_start;
  logic               div_busy;
  logic [CNT_W-1:0]   div_quot;
  logic [SLOTS_W-1:0] div_rem;

  // Datapath helpers.
  logic               in_xfer;
  logic               out_load;
  logic [CNT_W-1:0]   diff;
  logic               slot_last;
  logic [CNT_W-1:0]   slot_val;
  logic [CNT_W-1:0]   acc_base;
  logic [CNT_W-1:0]   acc_new;
  logic               m_wrap;
  logic               h_wrap;
  logic [IsW-1:0]     m_nxt;
  logic [MsW-1:0]     h_nxt;
  logic               k_last;
  logic               k_in_is;
  logic               k_in_ms;

  assign row     = item_q.counter_index[CtrW-1:0];
  assign in_xfer = in_valid_i && in_ready_o;

  // A counter without history counts its total from zero.
  assign diff = item_q.current_total[CNT_W-1:0]
              - (row_vld_q[row] ? prev_rdata[CNT_W-1:0] : '0);

  // The last slot of the update carries the remainder of the division.
  assign slot_last = (j_q == slots_q - SLOTS_W'(1));
  assign slot_val  = slot_last ? vlast_q : part_q;

  // The minute entry is folded in a running register; only the first slot
  // of an update needs the stored entry, fetched in the load state.
  assign acc_base = first_q ? mr_rdata : acc_q;
  assign acc_new  = (m_q == '0) ? slot_val : acc_base + slot_val;

  assign m_wrap = (m_q == IsW'(INTERVAL_SLOTS - 1));
  assign h_wrap = (h_q == MsW'(MINUTE_SLOTS - 1));
  assign m_nxt  = m_wrap ? '0 : m_q + IsW'(1);
  assign h_nxt  = m_wrap ? (h_wrap ? '0 : h_q + MsW'(1)) : h_q;

  assign k_last  = (k_q == KW'(KMax - 1));
  assign k_in_is = ({1'b0, k_q} < (KW + 1)'(INTERVAL_SLOTS));
  assign k_in_ms = ({1'b0, k_q} < (KW + 1)'(MINUTE_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state and the strobes to the divider and the storage.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    cmd        = '0;
    ir_waddr   = k_q[IsW-1:0];
    ir_wdata   = '0;
    mr_waddr   = k_q[MsW-1:0];
    mr_wdata   = '0;
    ir_raddr   = k_q[IsW-1:0];
    mr_raddr   = k_q[MsW-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_RDPREV;
        end
      end
      ST_RDPREV: begin
        state_d = ST_START;
      end
      ST_START: begin
        if (ctr_ok_q) begin
          div_start   = 1'b1;
          cmd.prev_we = 1'b1;
          state_d     = ST_DIV;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_DIV: begin
        // A counter seen for the first time has its rows zeroed meanwhile.
        if (clr_q) begin
          cmd.ir_we = k_in_is;
          cmd.mr_we = k_in_ms;
        end
        if (!div_busy && !clr_q) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mr_raddr = h_q;
        state_d  = ST_FILL;
      end
      ST_FILL: begin
        cmd.ir_we = ctr_ok_q;
        cmd.mr_we = ctr_ok_q;
        ir_waddr  = m_q;
        ir_wdata  = slot_val;
        mr_waddr  = h_q;
        mr_wdata  = acc_new;
        if (slot_last) begin
          state_d = ctr_ok_q ? ST_SUM : ST_OUT;
        end
      end
      ST_SUM: begin
        if (k_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      pos_m_q     <= '0;
      pos_h_q     <= '0;
      clr_q       <= 1'b0;
      irv_q       <= 1'b0;
      mrv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      irv_q <= (state_q == ST_SUM) && k_in_is;
      mrv_q <= (state_q == ST_SUM) && k_in_ms;
      if (state_q == ST_START && ctr_ok_q) begin
        clr_q          <= !row_vld_q[row];
        row_vld_q[row] <= 1'b1;
      end
      if (state_q == ST_DIV && clr_q && k_last) begin
        clr_q <= 1'b0;
      end
      // The ring position moves past every slot of the run's last update.
      if (state_q == ST_FILL && slot_last && item_q.end_of_run) begin
        pos_m_q <= m_nxt;
        pos_h_q <= h_nxt;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q   <= in_data_i;
      ctr_ok_q <= CmpW'(in_data_i.counter_index) < CmpW'(COUNTERS);
      slots_q  <= (in_data_i.slots == '0) ? SLOTS_W'(1) : in_data_i.slots;
    end
    if (irv_q) begin
      msum_q <= msum_q + ir_rdata;
    end
    if (mrv_q) begin
      hsum_q <= hsum_q + mr_rdata;
    end
    case (state_q)
      ST_START: begin
        m_q      <= pos_m_q;
        h_q      <= pos_h_q;
        j_q      <= '0;
        k_q      <= '0;
        first_q  <= 1'b1;
        newest_q <= '0;
        msum_q   <= '0;
        hsum_q   <= '0;
      end
      ST_DIV: begin
        if (clr_q) begin
          k_q <= k_q + KW'(1);
        end
      end
      ST_LOAD: begin
        part_q  <= div_quot;
        vlast_q <= div_quot + CNT_W'(div_rem);
        k_q     <= '0;
      end
      ST_FILL: begin
        first_q <= 1'b0;
        acc_q   <= acc_new;
        m_q     <= m_nxt;
        h_q     <= h_nxt;
        j_q     <= j_q + SLOTS_W'(1);
        if (ctr_ok_q) begin
          newest_q <= slot_val;
        end
      end
      ST_SUM: begin
        k_q <= k_q + KW'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.counter_echo   <= item_q.counter_index;
      out_q.interval_count <= newest_q;
      out_q.minute_sum     <= msum_q;
      out_q.hour_sum       <= hsum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  wert_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (slots_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  wert_store #(
    .CTR_DEPTH      (CtrDepth),
    .INTERVAL_SLOTS (INTERVAL_SLOTS),
    .MINUTE_SLOTS   (MINUTE_SLOTS)
  ) u_store (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .row_i        (row),
    .prev_wdata_i (item_q.current_total),
    .prev_rdata_o (prev_rdata),
    .ir_waddr_i   (ir_waddr),
    .ir_wdata_i   (ir_wdata),
    .ir_raddr_i   (ir_raddr),
    .ir_rdata_o   (ir_rdata),
    .mr_waddr_i   (mr_waddr),
    .mr_wdata_i   (mr_wdata),
    .mr_raddr_i   (mr_raddr),
    .mr_rdata_o   (mr_rdata)
  );

endmodule

// ----- design/wert_div.sv -----
// ============================================================================
// wert_div: iterative restoring divider
// Divides a 32-bit count by a 10-bit slot count, one quotient bit per cycle.
// ============================================================================
module wert_div import wert_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CNT_W-1:0]   dividend_i,
  input  logic [SLOTS_W-1:0] divisor_i,
  output logic               busy_o,
  output logic [CNT_W-1:0]   quot_o,
  output logic [SLOTS_W-1:0] rem_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0]     quot_q;
  logic [SLOTS_W-1:0]   rem_q;
  logic [SLOTS_W-1:0]   dvs_q;
  logic [SLOTS_W:0]     trial;
  logic [SLOTS_W:0]     trial_sub;
  logic                 fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial     = {rem_q, quot_q[CNT_W-1]};
    fits      = trial >= {1'b0, dvs_q};
    trial_sub = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(CNT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[CNT_W-2:0], fits};
      rem_q  <= fits ? trial_sub[SLOTS_W-1:0] : trial[SLOTS_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/wert_store.sv -----
// ============================================================================
// wert_store: per-counter storage
// Last totals, interval ring and minute ring, each with one write port and
// one registered read port, all addressed within the current counter's row.
// ============================================================================
module wert_store import wert_pkg::*; #(
  parameter int CTR_DEPTH      = COUNTERS_DEF,
  parameter int INTERVAL_SLOTS = INTERVAL_SLOTS_DEF,
  parameter int MINUTE_SLOTS   = MINUTE_SLOTS_DEF,
  localparam int CtrW          = (CTR_DEPTH > 1) ? $clog2(CTR_DEPTH) : 1,
  localparam int IsW           = $clog2(INTERVAL_SLOTS),
  localparam int MsW           = $clog2(MINUTE_SLOTS)
) (
  input  logic               clk_i,
  input  store_cmd_t         cmd_i,
  input  logic [CtrW-1:0]    row_i,
  input  logic [TOTAL_W-1:0] prev_wdata_i,
  output logic [TOTAL_W-1:0] prev_rdata_o,
  input  logic [IsW-1:0]     ir_waddr_i,
  input  logic [CNT_W-1:0]   ir_wdata_i,
  input  logic [IsW-1:0]     ir_raddr_i,
  output logic [CNT_W-1:0]   ir_rdata_o,
  input  logic [MsW-1:0]     mr_waddr_i,
  input  logic [CNT_W-1:0]   mr_wdata_i,
  input  logic [MsW-1:0]     mr_raddr_i,
  output logic [CNT_W-1:0]   mr_rdata_o
);

  logic [TOTAL_W-1:0] prev_mem [CTR_DEPTH];
  logic [CNT_W-1:0]   ir_mem   [CTR_DEPTH][INTERVAL_SLOTS];
  logic [CNT_W-1:0]   mr_mem   [CTR_DEPTH][MINUTE_SLOTS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prev_we) begin
      prev_mem[row_i] <= prev_wdata_i;
    end
    prev_rdata_o <= prev_mem[row_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ir_we) begin
      ir_mem[row_i][ir_waddr_i] <= ir_wdata_i;
    end
    ir_rdata_o <= ir_mem[row_i][ir_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mr_we) begin
      mr_mem[row_i][mr_waddr_i] <= mr_wdata_i;
    end
    mr_rdata_o <= mr_mem[row_i][mr_raddr_i];
  end

endmodule

// ----- design/wert_chk.sv -----
// ============================================================================
// wert_chk: port-level checks of the windowed event rate tracker
// Watches the handshakes and the result fields seen at the top level.
// ============================================================================
module wert_chk import wert_pkg::*; #(
  parameter int COUNTERS = COUNTERS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  localparam int CmpW = ($clog2(COUNTERS + 1) > CTR_IDX_W) ? $clog2(COUNTERS + 1)
                                                           : CTR_IDX_W;

  logic echo_oor;

  assign echo_oor = CmpW'(out_data_o.counter_echo) >= CmpW'(COUNTERS);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // The block works on one update at a time.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an input transfer");

  // The block only becomes ready again by handing over a result.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("ready returned without a result");

  // An index without a counter reports empty history.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && echo_oor |-> out_data_o.interval_count == '0
      && out_data_o.minute_sum == '0 && out_data_o.hour_sum == '0)
    else $error("nonzero result for an index without a counter");

endmodule

bind windowed_event_rate_tracker wert_chk #(
  .COUNTERS (COUNTERS)
) u_wert_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
